// ----- sv/kss_pkg.sv -----
// shared constants and types for the k-th smallest stream selector
package kss_pkg;

  localparam int MaxRank = 64;
  localparam int DataW   = 32;
  localparam int RankW   = 7;
  localparam int CntW    = $clog2(MaxRank + 1);
  localparam int KW      = (CntW > RankW) ? CntW : RankW;

  typedef struct packed {
    logic occ;
    logic en;
  } cell_ctrl_t;

endpackage

// ----- sv/kth_smallest_stream_select_unit.sv -----
// top level of the k-th smallest stream selector
// Keeps the k smallest values of the current set in a sorted chain of MaxRank cells; each
// beat is compared against every cell at once and inserted as it is accepted, so ordinary
// beats are taken one per cycle while no set result is pending. A beat flagged last is
// inserted, then the k-th smallest is read out of the chain into the result register once
// that register is free, and the next beat is stalled until then. A set with fewer than k
// values reports found = 0 and value 0. A rank of 0 acts as 1, a rank above the chain
// length as the chain length; write the rank only while no set result is pending.
module kth_smallest_stream_select_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kss_pkg::RankW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [kss_pkg::DataW-1:0]  sample_value_i,
  input  logic                              last_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [kss_pkg::DataW-1:0]  kth_value_o,
  output logic                              found_o
);
  import kss_pkg::*;

  logic [RankW-1:0]        rank_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         k_eff, cnt_trunc;
  logic [KW-1:0]           rank_ext;
  logic                    pend_q, pend_found_q;
  logic                    out_valid_q, found_q;
  logic signed [DataW-1:0] kth_q, rd_val;
  logic                    in_acc, full, gt_top, ins_en, out_load;

  logic [MaxRank-1:0]      sel, gt, take;
  logic signed [DataW-1:0] val [MaxRank];
  cell_ctrl_t              ctrl [MaxRank];

  assign in_stall_o = pend_q;
  assign in_acc     = in_valid_i && !pend_q;

  always_comb begin
    rank_ext = KW'(rank_q);
    if (rank_ext == '0) begin
      k_eff = CntW'(1);
    end else if (rank_ext > KW'(MaxRank)) begin
      k_eff = CntW'(MaxRank);
    end else begin
      k_eff = CntW'(rank_ext);
    end
    cnt_trunc = (cnt_q > k_eff) ? k_eff : cnt_q;
  end

  assign full   = (cnt_trunc == k_eff);
  assign gt_top = |(sel & gt);
  assign ins_en = in_acc && (!full || gt_top);

  genvar gi;
  generate
    for (gi = 0; gi < MaxRank; gi++) begin : g_cell
      localparam logic [CntW-1:0] Idx = CntW'(gi);
      logic                    prev_take;
      logic signed [DataW-1:0] prev_val;
      assign sel[gi]          = (k_eff == Idx + CntW'(1));
      assign ctrl[gi].occ     = (Idx < cnt_trunc);
      assign ctrl[gi].en      = ins_en;
      if (gi == 0) begin : g_head
        assign prev_take = 1'b0;
        assign prev_val  = sample_value_i;
      end else begin : g_body
        assign prev_take = take[gi-1];
        assign prev_val  = val[gi-1];
      end
      kss_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl[gi]),
        .sample_i    (sample_value_i),
        .prev_take_i (prev_take),
        .prev_val_i  (prev_val),
        .take_o      (take[gi]),
        .gt_o        (gt[gi]),
        .val_o       (val[gi])
      );
    end
  endgenerate

  // read the k-th cell by one-hot select
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < MaxRank; i++) begin
      rd_val = rd_val | (val[i] & {DataW{sel[i]}});
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      if (last_item_i) begin
        cnt_d = '0;
      end else if (full) begin
        cnt_d = cnt_trunc;
      end else begin
        cnt_d = cnt_trunc + CntW'(1);
      end
    end
  end

  assign out_load = pend_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q       <= RankW'(1);
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      pend_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rank_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      if (in_acc && last_item_i) begin
        pend_q       <= 1'b1;
        pend_found_q <= (cnt_trunc + CntW'(1)) >= k_eff;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        found_q     <= pend_found_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kth_q <= pend_found_q ? rd_val : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_q;
  assign found_o     = found_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRank))
    else $error("kept count beyond chain length");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_item_i) |=> (pend_q && cnt_q == '0))
    else $error("last beat did not open a pending result");

  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pend_q))
    else $error("result beat without pending set");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (kth_value_o == '0))
    else $error("missing result carries nonzero value");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(sel))
    else $error("rank select not one-hot");

endmodule

// ----- sv/kss_cell.sv -----
// one cell of the sorted insertion chain
module kss_cell (
  input  logic                              clk_i,
  input  kss_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [kss_pkg::DataW-1:0]  sample_i,
  input  logic                              prev_take_i,
  input  logic signed [kss_pkg::DataW-1:0]  prev_val_i,
  output logic                              take_o,
  output logic                              gt_o,
  output logic signed [kss_pkg::DataW-1:0]  val_o
);
  import kss_pkg::*;

  logic signed [DataW-1:0] val_q, val_d;

  assign gt_o   = ctrl_i.occ && (val_q > sample_i);
  assign take_o = !ctrl_i.occ || gt_o;
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.en && take_o) begin
      val_d = prev_take_i ? prev_val_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- test/tb_top.sv -----
// testbench for the k-th smallest stream selector: scoreboard, stimulus and checks
`timescale 1ns / 100ps

module tb_top;

  localparam int MaxK = kss_pkg::MaxRank;

  typedef logic signed [kss_pkg::DataW-1:0] sample_t;
  typedef logic [kss_pkg::RankW-1:0] rank_t;

  typedef struct {
    sample_t kth;
    logic    found;
  } kth_result_t;

  class kth_book;
    sample_t          kept [MaxK];
    int unsigned      n_kept;
    rank_t            rank_reg;
    kth_result_t      pending [$];
    int unsigned      n_err;

    function new();
      n_kept   = 0;
      rank_reg = 1;
      n_err    = 0;
    endfunction

    function int unsigned eff_rank();
      if (rank_reg == 0) return 1;
      if (rank_reg > MaxK) return MaxK;
      return rank_reg;
    endfunction

    function void insert(sample_t v);
      int unsigned p;
      p = n_kept;
      while (p > 0 && kept[p-1] > v) begin
        kept[p] = kept[p-1];
        p--;
      end
      kept[p] = v;
      n_kept++;
    endfunction

    function void note_beat(sample_t v, logic l);
      int unsigned k;
      kth_result_t r;
      k = eff_rank();
      if (n_kept > k) n_kept = k;
      if (n_kept < k) begin
        insert(v);
      end else if (v < kept[k-1]) begin
        n_kept = k - 1;
        insert(v);
      end
      if (l) begin
        if (n_kept >= k) begin
          r.kth   = kept[k-1];
          r.found = 1'b1;
        end else begin
          r.kth   = '0;
          r.found = 1'b0;
        end
        pending = {pending, r};
        n_kept = 0;
      end
    endfunction

    function void check_beat(sample_t v, logic f);
      kth_result_t want;
      if (pending.size() == 0) begin
        $error("result with no set pending: kth_value %0d found %0b", v, f);
        n_err++;
        return;
      end
      want = pending.pop_front();
      if (v !== want.kth) begin
        $error("kth_value: expected %0d, actual %0d", want.kth, v);
        n_err++;
      end
      if (f !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, f);
        n_err++;
      end
    endfunction
  endclass

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    cfg_we    = 1'b0;
  rank_t   cfg_wdata = '0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  sample_t sample    = '0;
  logic    last      = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t kth_value;
  logic    found;

  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;
  bit hold_req = 1'b0;
  int n_sent   = 0;

  kth_book book = new();

  rank_t phase_rank [14] = '{7'd2, 7'd1, 7'd64, 7'd5, 7'd127, 7'd3, 7'd0,
                             7'd8, 7'd65, 7'd4, 7'd12, 7'd2, 7'd6, 7'd1};

  kth_smallest_stream_select_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_value_i (sample),
    .last_item_i    (last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kth_value_o    (kth_value),
    .found_o        (found)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) book.check_beat(kth_value, found);
  end

  // receiver: random stall, with a long hold-off on request
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < 150; held++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= calm_out ? 1'b0 : ($urandom_range(99) < 25);
    end
  end

  function automatic sample_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return sample_t'($urandom_range(15)) - 8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(input sample_t v, input logic l);
    if (!calm_in && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    last     <= l;
    do @(posedge clk); while (in_stall);
    book.note_beat(v, l);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rank(input rank_t r);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    book.rank_reg = r;
    cfg_we <= 1'b0;
  endtask

  task automatic send_set(input int len, input bit may_cut);
    int cut;
    cut = -1;
    if (may_cut && len >= 2 && $urandom_range(7) == 0) cut = $urandom_range(1, len - 1);
    for (int i = 0; i < len; i++) begin
      if (i == cut) write_rank(rank_t'($urandom_range(0, 9)));
      send_beat(pick_value(), i == len - 1);
    end
  endtask

  initial begin : main
    int p;
    int k;
    int len;
    int budget;
    int phase_start;
    bit squeeze;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rank 1 after reset: extremes of the value range
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd0, 1'b1);
    send_beat(32'sd5, 1'b1);
    // set shorter than the rank
    write_rank(7'd3);
    send_beat(32'sd7, 1'b0);
    send_beat(-32'sd7, 1'b1);
    // equal values
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd2, 1'b1);
    // rank zero acts as one
    write_rank(7'd0);
    send_beat(32'sd9, 1'b0);
    send_beat(32'sd3, 1'b1);
    // rank lowered within a set
    write_rank(7'd5);
    send_beat(32'sd10, 1'b0);
    send_beat(32'sd20, 1'b0);
    send_beat(32'sd30, 1'b0);
    send_beat(32'sd40, 1'b0);
    send_beat(32'sd50, 1'b0);
    write_rank(7'd2);
    send_beat(32'sd60, 1'b1);
    // rank raised within a set
    send_beat(32'sd8, 1'b0);
    send_beat(32'sd1, 1'b0);
    send_beat(32'sd5, 1'b0);
    write_rank(7'd4);
    send_beat(32'sd3, 1'b0);
    send_beat(32'sd9, 1'b1);

    p = 0;
    while (n_sent < 520) begin
      write_rank(phase_rank[p % 14]);
      squeeze  = (p == 1);
      calm_in  = squeeze || (p == 3);
      calm_out = (p == 3);
      if (squeeze) hold_req = 1'b1;
      k = book.eff_rank();
      budget = (k > 16) ? 75 : 45;
      phase_start = n_sent;
      while (n_sent - phase_start < budget) begin
        k = book.eff_rank();
        if (squeeze) len = $urandom_range(1, 3);
        else if ($urandom_range(4) == 0) len = $urandom_range(1, (k > 1) ? k - 1 : 1);
        else len = $urandom_range(k, k + 6);
        send_set(len, !squeeze);
      end
      p++;
    end
    calm_in  = 1'b0;
    calm_out = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (book.n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/kss_pkg.sv
sv/kss_cell.sv
sv/kth_smallest_stream_select_unit.sv
test/tb_top.sv
